/* hdl/bdhws_pkg.sv */
// Shared package of the base-digit half-weight split core.
// Holds widths, microcode opcodes, jump conditions and the control structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bdhws_pkg;

    // Datapath sizing.
    localparam int VALUE_BITS = 64;
    localparam int IO_W       = 64;
    localparam int RADIX_W    = 16;
    localparam int RADIX_MIN  = 2;
    localparam int ADDR_W     = $clog2(VALUE_BITS);
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LO_W       = (VALUE_BITS + 1) / 2;
    localparam int HI_W       = VALUE_BITS - LO_W;
    localparam int PROD_W     = RADIX_W + LO_W;

    // Microprogram addressing.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE     = t_step'(0);
    localparam t_step ST_P1_HEAD  = t_step'(1);
    localparam t_step ST_DIV_CLR  = t_step'(2);
    localparam t_step ST_DIV_STEP = t_step'(3);
    localparam t_step ST_DIGIT    = t_step'(4);
    localparam t_step ST_P2_SETUP = t_step'(5);
    localparam t_step ST_P2_HEAD  = t_step'(6);
    localparam t_step ST_DMUL_LO  = t_step'(7);
    localparam t_step ST_DMUL_HI  = t_step'(8);
    localparam t_step ST_ACC_HI   = t_step'(9);
    localparam t_step ST_WMUL_LO  = t_step'(10);
    localparam t_step ST_WMUL_HI  = t_step'(11);
    localparam t_step ST_WUPD     = t_step'(12);
    localparam t_step ST_EMIT     = t_step'(13);

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_CLR,
        OP_DIV_STEP,
        OP_DIGIT,
        OP_SETUP2,
        OP_DMUL_LO,
        OP_DMUL_HI,
        OP_ACC_HI,
        OP_WMUL_LO,
        OP_WMUL_HI,
        OP_WUPD,
        OP_EMIT
    } t_op;

    // Jump conditions; C_NEXT always falls through.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_START,
        C_N_ZERO,
        C_DIV_MORE,
        C_SCAN_END,
        C_NOW_REACHED
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jump;
    } t_uword;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic n_zero;
        logic div_more;
        logic scan_end;
        logic now_reached;
    } t_flags;

endpackage

`default_nettype wire

/* hdl/bdhws_useq.sv */
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on bdhws_pkg for the opcode, condition and struct types.
`default_nettype none

module bdhws_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdhws_pkg::t_flags i_flags,
    output bdhws_pkg::t_uword o_uword,
    output logic              o_busy
);
    import bdhws_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   take;

    // Control store: one word per step.
    always_comb begin
        case (r_pc)
            ST_IDLE:     uw = '{OP_LOAD,     C_NOT_START,   ST_IDLE};
            ST_P1_HEAD:  uw = '{OP_NOP,      C_N_ZERO,      ST_P2_SETUP};
            ST_DIV_CLR:  uw = '{OP_DIV_CLR,  C_NEXT,        ST_IDLE};
            ST_DIV_STEP: uw = '{OP_DIV_STEP, C_DIV_MORE,    ST_DIV_STEP};
            ST_DIGIT:    uw = '{OP_DIGIT,    C_ALWAYS,      ST_P1_HEAD};
            ST_P2_SETUP: uw = '{OP_SETUP2,   C_NEXT,        ST_IDLE};
            ST_P2_HEAD:  uw = '{OP_NOP,      C_SCAN_END,    ST_EMIT};
            ST_DMUL_LO:  uw = '{OP_DMUL_LO,  C_NEXT,        ST_IDLE};
            ST_DMUL_HI:  uw = '{OP_DMUL_HI,  C_NEXT,        ST_IDLE};
            ST_ACC_HI:   uw = '{OP_ACC_HI,   C_NOW_REACHED, ST_EMIT};
            ST_WMUL_LO:  uw = '{OP_WMUL_LO,  C_NEXT,        ST_IDLE};
            ST_WMUL_HI:  uw = '{OP_WMUL_HI,  C_NEXT,        ST_IDLE};
            ST_WUPD:     uw = '{OP_WUPD,     C_ALWAYS,      ST_P2_HEAD};
            ST_EMIT:     uw = '{OP_EMIT,     C_ALWAYS,      ST_IDLE};
            default:     uw = '{OP_NOP,      C_ALWAYS,      ST_IDLE};
        endcase
    end

    // Jump decision and next step.
    always_comb begin
        case (uw.cond)
            C_NEXT:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NOT_START:   take = !i_flags.start;
            C_N_ZERO:      take = i_flags.n_zero;
            C_DIV_MORE:    take = i_flags.div_more;
            C_SCAN_END:    take = i_flags.scan_end;
            C_NOW_REACHED: take = i_flags.now_reached;
            default:       take = 1'b1;
        endcase
        n_pc = take ? uw.jump : r_pc + t_step'(1);
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_busy  = (r_pc != ST_IDLE);

endmodule

`default_nettype wire

/* hdl/base_digit_half_weight_split_core.sv */
// Top level of the base-digit half-weight split core: datapath and digit memory.
// Depends on bdhws_pkg and on the microcode sequencer bdhws_useq.
//
//   channel   handshake            payload          width
//   input     start, busy          i_value          64
//   result    o_valid (strobe)     o_split_value    64
//   config    i_cfg_we             i_cfg_wdata      16 (radix)
//
// A transaction runs a first pass that divides the value by the radix and stores each digit,
// then a second pass that scans the stored digits; a zero value skips both loops.
// The bit-serial divider yields one quotient bit per cycle, over all 64 bits of the value for each digit.
// Reset is synchronous and active low; it returns the radix to 2 and the sequencer to idle.
// The result strobe lasts one cycle and the receiver cannot stall it; a new start is
// taken in the same cycle that the strobe is shown.
`default_nettype none

module base_digit_half_weight_split_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bdhws_pkg::IO_W-1:0]   i_value,
    input  logic                         i_cfg_we,
    input  logic [bdhws_pkg::RADIX_W-1:0] i_cfg_wdata,
    output logic                         o_valid,
    output logic [bdhws_pkg::IO_W-1:0]   o_split_value
);
    import bdhws_pkg::*;

    t_flags flags;
    t_uword uw;

    // Configuration and datapath registers.
    logic [RADIX_W-1:0]    r_radix;
    logic [VALUE_BITS-1:0] r_n;
    logic [RADIX_W-1:0]    r_rem;
    logic [ADDR_W-1:0]     r_bit;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_w;
    logic [CNT_W-1:0]      r_target;
    logic [CNT_W-1:0]      r_now;
    logic [CNT_W-1:0]      r_k;
    logic [RADIX_W-1:0]    r_rd;
    logic [PROD_W-1:0]     r_prod;
    logic [VALUE_BITS-1:0] r_sum;
    logic [VALUE_BITS-1:0] r_weight;
    logic [VALUE_BITS-1:0] r_wnext;
    logic                  r_valid;
    logic [IO_W-1:0]       r_split;
    logic [RADIX_W-1:0]    r_dig_mem [MEM_DEPTH];

    logic [RADIX_W-1:0]          radix_eff;
    logic [RADIX_W:0]            div_t;
    logic                        div_ge;
    logic [RADIX_W:0]            div_diff;
    logic [RADIX_W-1:0]          rem_next;
    logic                        hi_sel;
    logic [RADIX_W-1:0]          mul_a;
    logic [LO_W-1:0]             mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [PROD_W+VALUE_BITS-1:0] prod_wide;
    logic [VALUE_BITS-1:0]       prod_lo_ext;
    logic [VALUE_BITS-1:0]       prod_hi_shift;

    bdhws_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_busy  (busy)
    );

    // A radix below two is treated as two.
    assign radix_eff = (r_radix < RADIX_W'(RADIX_MIN)) ? RADIX_W'(RADIX_MIN) : r_radix;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign div_t    = {r_rem, r_n[VALUE_BITS-1]};
    assign div_ge   = (div_t >= {1'b0, radix_eff});
    assign div_diff = div_t - {1'b0, radix_eff};
    assign rem_next = div_ge ? div_diff[RADIX_W-1:0] : div_t[RADIX_W-1:0];

    // Shared multiplier: digit or radix times one half of the running weight.
    assign hi_sel = (uw.op == OP_DMUL_HI) || (uw.op == OP_WMUL_HI);
    assign mul_a  = ((uw.op == OP_WMUL_LO) || (uw.op == OP_WMUL_HI)) ? radix_eff : r_rd;
    assign mul_b  = hi_sel ? LO_W'(r_weight[VALUE_BITS-1:LO_W]) : r_weight[LO_W-1:0];
    assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Low partial product at full width, high partial product moved to its place.
    assign prod_wide     = {{VALUE_BITS{1'b0}}, r_prod};
    assign prod_lo_ext   = prod_wide[VALUE_BITS-1:0];
    assign prod_hi_shift = {r_prod[HI_W-1:0], {LO_W{1'b0}}};

    // Status for the sequencer.
    assign flags.start       = start;
    assign flags.n_zero      = (r_n == '0);
    assign flags.div_more    = (r_bit != ADDR_W'(VALUE_BITS - 1));
    assign flags.scan_end    = (r_k == r_idx);
    assign flags.now_reached = (r_now >= r_target);

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_W'(RADIX_MIN);
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    // Digit memory: written once per digit in the first pass, read registered.
    always_ff @(posedge i_clk) begin
        if (uw.op == OP_DIGIT) begin
            r_dig_mem[r_idx[ADDR_W-1:0]] <= r_rem;
        end
        r_rd <= r_dig_mem[r_k[ADDR_W-1:0]];
    end

    // Datapath actions, one per control word.
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_LOAD: begin
                r_n      <= i_value[VALUE_BITS-1:0];
                r_idx    <= '0;
                r_w      <= '0;
                r_sum    <= '0;
                r_weight <= VALUE_BITS'(1);
            end
            OP_DIV_CLR: begin
                r_rem <= '0;
                r_bit <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_next;
                r_n   <= {r_n[VALUE_BITS-2:0], div_ge};
                r_bit <= r_bit + ADDR_W'(1);
            end
            OP_DIGIT: begin
                if (r_rem != '0) begin
                    r_w <= r_w + CNT_W'(1);
                end
                r_idx <= r_idx + CNT_W'(1);
            end
            OP_SETUP2: begin
                r_target <= r_w >> 1;
                r_now    <= '0;
                r_k      <= '0;
            end
            OP_DMUL_LO: begin
                r_prod <= mul_p;
            end
            OP_DMUL_HI: begin
                r_sum  <= r_sum + prod_lo_ext;
                r_prod <= PROD_W'(mul_p[HI_W-1:0]);
                if (r_rd != '0) begin
                    r_now <= r_now + CNT_W'(1);
                end
            end
            OP_ACC_HI: begin
                r_sum <= r_sum + prod_hi_shift;
            end
            OP_WMUL_LO: begin
                r_prod <= mul_p;
                r_k    <= r_k + CNT_W'(1);
            end
            OP_WMUL_HI: begin
                r_wnext <= prod_lo_ext;
                r_prod  <= PROD_W'(mul_p[HI_W-1:0]);
            end
            OP_WUPD: begin
                r_weight <= r_wnext + prod_hi_shift;
            end
            OP_EMIT: begin
                r_split <= IO_W'(r_sum);
            end
            default: begin
            end
        endcase
    end

    // Result strobe, one cycle per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (uw.op == OP_EMIT);
        end
    end

    assign o_valid       = r_valid;
    assign o_split_value = r_split;

endmodule

`default_nettype wire

/* tb/sv/base_digit_half_weight_split_core_test.sv */
// Self-checking testbench for the base-digit half-weight split core.
// Drives values and radix writes from a job queue and checks every split result.
// Depends on bdhws_pkg and base_digit_half_weight_split_core.
`timescale 1ns / 1ps

module base_digit_half_weight_split_core_test;

    import bdhws_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 60000;
    localparam int SETTLE_CYCLES = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 15;

    // Kinds of work the driver takes from the job queue.
    typedef enum logic [1:0] {
        JOB_VALUE,
        JOB_RADIX,
        JOB_SETTLE
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        logic [63:0] data;
        int          gap;
    } t_job;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [IO_W-1:0]      i_value = '0;
    logic                 i_cfg_we = 1'b0;
    logic [RADIX_W-1:0]   i_cfg_wdata = '0;
    logic                 o_valid;
    logic [IO_W-1:0]      o_split_value;

    t_job                 job_q[$];
    logic [63:0]          expected_splits[$];
    logic                 split_pend_valid = 1'b0;
    logic [63:0]          split_pend = '0;
    logic [RADIX_W-1:0]   radix_copy = RADIX_W'(2);
    logic                 drv_idle = 1'b0;
    int                   n_issued = 0;
    int                   n_done = 0;
    int                   n_errors = 0;
    int                   idle_cycles = 0;
    int                   wait_cnt = 0;

    base_digit_half_weight_split_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_split_value (o_split_value)
    );

    always begin
        #HALF_PERIOD i_clk = ~i_clk;
    end

    // Expected split: low digits of the value up to where half of its nonzero
    // digits (rounded down) have been seen. Radix 0 and 1 behave as radix 2.
    function automatic logic [63:0] split_for_radix(logic [63:0] value,
                                                    logic [RADIX_W-1:0] radix_cfg);
        logic [63:0] base;
        logic [63:0] n;
        logic [63:0] weight;
        logic [63:0] sum;
        logic [63:0] digit;
        int          nonzero;
        int          half;
        int          seen;
        base    = (radix_cfg < RADIX_W'(RADIX_MIN)) ? 64'(RADIX_MIN) : 64'(radix_cfg);
        n       = value & ({64{1'b1}} >> (64 - VALUE_BITS));
        weight  = 64'd1;
        sum     = '0;
        nonzero = 0;
        seen    = 0;
        while (n != 0) begin
            if (n % base != 0)
                nonzero++;
            n = n / base;
        end
        half = nonzero / 2;
        n = value & ({64{1'b1}} >> (64 - VALUE_BITS));
        while (n != 0) begin
            digit = n % base;
            if (digit != 0) begin
                seen++;
                sum = sum + digit * weight;
            end
            if (seen >= half)
                break;
            n      = n / base;
            weight = weight * base;
        end
        return sum;
    endfunction

    // Random value for a given radix: mostly random widths, some full-width
    // words and some with sparse digits so the half count lands in odd places.
    function automatic logic [63:0] draw_value(logic [RADIX_W-1:0] radix_cfg);
        logic [63:0] base;
        logic [63:0] v;
        logic [63:0] w;
        int unsigned pick;
        base = (radix_cfg < RADIX_W'(RADIX_MIN)) ? 64'(RADIX_MIN) : 64'(radix_cfg);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            v = {$urandom, $urandom} >> $urandom_range(0, 63);
        end else if (pick < 8) begin
            v = {$urandom, $urandom};
        end else begin
            v = '0;
            w = 64'd1;
            for (int k = 0; k < 64; k++) begin
                if ($urandom_range(0, 2) == 0)
                    v = v + w * 64'($urandom_range(1, int'(base) - 1));
                if (w > {64{1'b1}} / base)
                    break;
                w = w * base;
            end
        end
        return v;
    endfunction

    task automatic push_value(logic [63:0] value, int gap);
        job_q.insert(job_q.size(), t_job'{kind: JOB_VALUE, data: value, gap: gap});
    endtask

    task automatic push_radix(logic [RADIX_W-1:0] radix_cfg);
        job_q.insert(job_q.size(), t_job'{kind: JOB_RADIX, data: 64'(radix_cfg), gap: 0});
    endtask

    task automatic push_settle();
        job_q.insert(job_q.size(), t_job'{kind: JOB_SETTLE, data: '0, gap: 0});
    endtask

    // Driver: presents values on start/busy and writes the radix only when the
    // core has returned every result and is not busy.
    always @(posedge i_clk) begin : driver
        logic               take;
        logic               nxt_start;
        logic               nxt_we;
        logic [IO_W-1:0]    nxt_value;
        logic [RADIX_W-1:0] nxt_wdata;
        int                 in_flight;
        t_job               head;
        take      = start && !busy;
        nxt_start = start && !take;
        nxt_we    = 1'b0;
        nxt_value = i_value;
        nxt_wdata = i_cfg_wdata;
        in_flight = n_issued - n_done + int'(take);
        if (!i_rst_n) begin
            radix_copy = RADIX_W'(2);
            wait_cnt   = 0;
            start            <= 1'b0;
            i_cfg_we         <= 1'b0;
            split_pend_valid <= 1'b0;
            drv_idle         <= 1'b0;
        end else begin
            if (!nxt_start && job_q.size() > 0) begin
                head = job_q[0];
                case (head.kind)
                    JOB_VALUE: begin
                        if (wait_cnt < head.gap) begin
                            wait_cnt++;
                        end else begin
                            nxt_start = 1'b1;
                            nxt_value = head.data;
                            wait_cnt  = 0;
                            void'(job_q.pop_front());
                        end
                    end
                    JOB_RADIX: begin
                        if (in_flight <= 0 && !busy && !i_cfg_we) begin
                            nxt_we     = 1'b1;
                            nxt_wdata  = head.data[RADIX_W-1:0];
                            radix_copy = head.data[RADIX_W-1:0];
                            void'(job_q.pop_front());
                        end
                    end
                    JOB_SETTLE: begin
                        if (in_flight <= 0)
                            void'(job_q.pop_front());
                    end
                    default: begin
                        void'(job_q.pop_front());
                    end
                endcase
            end
            // Hand the prediction of an accepted transaction to the monitor.
            split_pend_valid <= take;
            split_pend       <= split_for_radix(i_value, radix_copy);
            n_issued         <= n_issued + int'(take);
            start            <= nxt_start;
            i_value          <= nxt_value;
            i_cfg_we         <= nxt_we;
            i_cfg_wdata      <= nxt_wdata;
            drv_idle         <= (job_q.size() == 0) && !nxt_start && !nxt_we;
        end
    end

    // Monitor: every strobe is checked against the oldest expected split.
    always @(posedge i_clk) begin : monitor
        logic [63:0] want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_splits.size() == 0) begin
                    $display("%0t: result with none expected: expected none, actual %h",
                             $time, o_split_value);
                    n_errors++;
                end else begin
                    want = expected_splits.pop_front();
                    if (o_split_value !== want) begin
                        $display("%0t: split_value mismatch: expected %h, actual %h",
                                 $time, want, o_split_value);
                        n_errors++;
                    end
                end
                n_done <= n_done + 1;
            end
            if (split_pend_valid)
                expected_splits.insert(expected_splits.size(), split_pend);
        end
    end

    // Watchdog on cycles in which no transaction and no result is seen.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [RADIX_W-1:0] phase_radix;
        logic               no_idle;

        // Directed part, first at the reset radix of 2.
        push_value(64'd0, 0);                       // zero value gives zero
        push_value({64{1'b1}}, 0);                  // all ones in binary
        push_value(64'd1, 1);
        push_value(64'd2, 0);
        push_value(64'd3, 2);
        push_value(64'h8000_0000_0000_0000, 0);
        push_value(64'h5555_5555_5555_5555, 0);
        push_value(64'hAAAA_AAAA_AAAA_AAAA, 3);
        push_settle();                              // hold off until all results are back
        push_radix(16'hFFFF);                       // largest radix
        push_value(64'd0, 0);
        push_value({64{1'b1}}, 0);
        push_value(64'd65534, 1);
        push_value(64'd65535, 0);
        push_value(64'd65536, 0);
        push_value(64'h0001_0000_0000_0001, 4);
        push_value(64'hFFFE_0000_FFFE_0001, 0);
        push_radix(16'd0);                          // radix below two saturates
        push_value(64'd5, 0);
        push_value(64'hF0F0_0000_0000_000F, 0);
        push_radix(16'd1);
        push_value(64'd7, 0);
        push_radix(16'd3);                          // smallest radix above two
        push_value(64'd1, 0);
        push_value(64'd2, 0);
        push_value(64'd10, 0);
        push_value({64{1'b1}}, 2);

        // Random phases, each under its own radix.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: phase_radix = 16'd10;
                1: phase_radix = 16'hFFFF;
                2: phase_radix = 16'd16;
                3: phase_radix = 16'd2;
                4: phase_radix = 16'd3;
                6: phase_radix = 16'd7;
                default: phase_radix = RADIX_W'($urandom_range(4, 65535));
            endcase
            no_idle = (p % 3 == 1);
            push_radix(phase_radix);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
                    push_settle();
                push_value(draw_value(phase_radix), no_idle ? 0 : $urandom_range(0, 4));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the job queue to empty and every result to come back.
        @(posedge i_clk);
        while (!(drv_idle && n_issued == n_done))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_splits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
